// ----- sv/box_support_point_defines.svh -----
`ifndef BOX_SUPPORT_POINT_DEFINES_SVH
`define BOX_SUPPORT_POINT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define BSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box_support_point: implication check failed");

// condition that must never be seen outside reset
`define BSP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("box_support_point: forbidden condition seen");

`endif

// ----- sv/bsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

  localparam int DIR_W      = 16;
  localparam int SIZE_W     = 20;
  localparam int ROT_W      = 16;
  localparam int ORG_W      = 20;
  localparam int PT_W       = 21;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int FRAC_SHIFT = 15;

  // dir * rot products, their sum over three axes
  localparam int PROD_W   = DIR_W + ROT_W;
  localparam int RSUM_W   = PROD_W + 1;
  // size * rot, corner coordinate, rounded coordinate
  localparam int M_W      = SIZE_W + ROT_W;
  localparam int CORNER_W = M_W + 2;
  localparam int RND_W    = CORNER_W - FRAC_SHIFT;

  localparam int QUEUE_DEPTH_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_ORIGIN = 3'd6;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 20'd256;
  localparam logic [3*ROT_W-1:0] ROT_X_RST = 48'h0000_0000_4000;
  localparam logic [3*ROT_W-1:0] ROT_Y_RST = 48'h0000_4000_0000;
  localparam logic [3*ROT_W-1:0] ROT_Z_RST = 48'h4000_0000_0000;

  // positive-half flags of each corner, bit 0 x, bit 1 y, bit 2 z
  localparam logic [7:0][2:0] CORNER_POS = {
    3'b110, 3'b111, 3'b101, 3'b100, 3'b010, 3'b011, 3'b001, 3'b000
  };

  typedef struct packed {
    logic [2:0][SIZE_W-1:0]       size;
    logic [2:0][2:0][ROT_W-1:0]   rot;
    logic [2:0][ORG_W-1:0]        org;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } entry_t;

  // lowest corner whose signs agree with want on every axis not marked free
  function automatic logic [IDX_W-1:0] pick_corner(input logic [2:0] want,
                                                   input logic [2:0] free);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (((CORNER_POS[i] ^ want) & ~free) == 3'b000) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bsp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsp_front import bsp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    take_i,
  input  wire logic signed [DIR_W-1:0] dir_x_i,
  input  wire logic signed [DIR_W-1:0] dir_y_i,
  input  wire logic signed [DIR_W-1:0] dir_z_i,
  input  wire cfg_t                    cfg_i,
  output entry_t                       push_o,
  output logic [1:0]                   inflight_o
);

  logic v1_q, v2_q, v3_q;
  logic signed [DIR_W-1:0]  dir_q [3];
  logic signed [PROD_W-1:0] t_d   [3][3];
  logic signed [PROD_W-1:0] t_q   [3][3];
  logic signed [RSUM_W-1:0] r_d   [3];
  logic signed [RSUM_W-1:0] r_q   [3];
  logic [2:0] want;
  logic [2:0] free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        t_d[a][j] = dir_q[j] * $signed(cfg_i.rot[a][j]);
      end
      r_d[a] = $signed({t_q[a][0][PROD_W-1], t_q[a][0]})
             + $signed({t_q[a][1][PROD_W-1], t_q[a][1]})
             + $signed({t_q[a][2][PROD_W-1], t_q[a][2]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      dir_q[0] <= dir_x_i;
      dir_q[1] <= dir_y_i;
      dir_q[2] <= dir_z_i;
    end
    t_q <= t_d;
    r_q <= r_d;
  end

  // projection is sum of +-size*r per axis, so the best corner takes the sign
  // of r on each axis; a zero term leaves that axis free and the lowest index wins
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      want[a] = ~r_q[a][RSUM_W-1];
      free[a] = (r_q[a] == '0) || (cfg_i.size[a] == '0);
    end
  end

  assign push_o.valid = v3_q;
  assign push_o.idx   = pick_corner(want, free);
  assign inflight_o   = 2'({1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q});

endmodule

`default_nettype wire

// ----- sv/bsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsp_queue import bsp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire entry_t                     push_i,
  output entry_t                          head_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pop;
  logic             head_valid_q;
  logic [IDX_W-1:0] head_idx_q;

  // back end never stalls, so a stored word leaves on the next cycle
  assign pop = (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
      head_valid_q <= 1'b0;
    end else begin
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      count_q      <= count_d;
      head_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_ptr_q] <= push_i.idx;
    end
    if (pop) begin
      head_idx_q <= mem[rd_ptr_q];
    end
  end

  assign head_o.valid = head_valid_q;
  assign head_o.idx   = head_idx_q;
  assign count_o      = count_q;

endmodule

`default_nettype wire

// ----- sv/bsp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsp_back import bsp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire entry_t                 head_i,
  input  wire cfg_t                   cfg_i,
  output logic                        done_o,
  output logic signed [PT_W-1:0]      point_x_o,
  output logic signed [PT_W-1:0]      point_y_o,
  output logic signed [PT_W-1:0]      point_z_o,
  output logic [IDX_W-1:0]            corner_index_o
);

  localparam logic signed [CORNER_W-1:0] ROUND_C = CORNER_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W - PT_W + 1){1'b0}}, {(PT_W - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO =
    {{(RND_W - PT_W + 1){1'b1}}, {(PT_W - 1){1'b0}}};

  logic signed [M_W:0]      prod  [3][3];
  logic signed [M_W-1:0]    m_q   [3][3];
  logic signed [CORNER_W-1:0] term;
  logic signed [CORNER_W-1:0] cs_d [3];
  logic signed [CORNER_W-1:0] cs_q [3];
  logic signed [CORNER_W-1:0] sum  [3];
  logic signed [RND_W-1:0]  rq_d  [3];
  logic signed [RND_W-1:0]  rq_q  [3];
  logic signed [PT_W-1:0]   pt_d  [3];
  logic signed [PT_W-1:0]   pt_q  [3];
  logic [2:0]               pos;
  logic                     v1_q, v2_q, done_q;
  logic [IDX_W-1:0]         idx1_q, idx2_q, idx3_q;

  // size * rotation terms are registered from the config, so they follow it in the next cycle
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        prod[a][j] = $signed({1'b0, cfg_i.size[a]}) * $signed(cfg_i.rot[a][j]);
      end
    end
  end

  always_comb begin
    pos  = CORNER_POS[head_i.idx];
    term = '0;
    for (int j = 0; j < 3; j++) begin
      cs_d[j] = '0;
      for (int a = 0; a < 3; a++) begin
        term    = $signed({{2{m_q[a][j][M_W-1]}}, m_q[a][j]});
        cs_d[j] = pos[a] ? cs_d[j] + term : cs_d[j] - term;
      end
    end
  end

  // add origin, round half up, floor by arithmetic bit select
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = cs_q[j]
             + $signed({{(CORNER_W - ORG_W - FRAC_SHIFT){cfg_i.org[j][ORG_W-1]}},
                        cfg_i.org[j], {FRAC_SHIFT{1'b0}}})
             + ROUND_C;
      rq_d[j] = sum[j][CORNER_W-1:FRAC_SHIFT];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (rq_q[j] > SAT_HI) begin
        pt_d[j] = SAT_HI[PT_W-1:0];
      end else if (rq_q[j] < SAT_LO) begin
        pt_d[j] = SAT_LO[PT_W-1:0];
      end else begin
        pt_d[j] = rq_q[j][PT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= head_i.valid;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        m_q[a][j] <= prod[a][j][M_W-1:0];
      end
    end
    cs_q   <= cs_d;
    rq_q   <= rq_d;
    pt_q   <= pt_d;
    idx1_q <= head_i.idx;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  assign done_o         = done_q;
  assign point_x_o      = pt_q[0];
  assign point_y_o      = pt_q[1];
  assign point_z_o      = pt_q[2];
  assign corner_index_o = idx3_q;

endmodule

`default_nettype wire

// ----- sv/box_support_point.sv -----
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  query     | dir_x_i, dir_y_i, dir_z_i                 | start high, busy low
//  result    | point_x_o, point_y_o, point_z_o,          | done_o strobe, one cycle
//            | corner_index_o                            |
//  config    | cfg_index_i, cfg_data_i                   | cfg_we_i, no wait
//
//  one query per cycle while busy is low; done_o rises once a query has passed
//  the multiply, sum, classify, queue, corner, round and saturate stages, and the
//  result is valid while done_o is high
//  reset clears valid bits, the queue and the registers to their defaults
//  the result side cannot stall; busy rises only if the queue plus the front stages
//  could overflow it, which steady one-per-cycle traffic never reaches above depth 4
`timescale 1ns / 1ps
`default_nettype none

module box_support_point import bsp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [DIR_W-1:0]   dir_x_i,
  input  wire logic signed [DIR_W-1:0]   dir_y_i,
  input  wire logic signed [DIR_W-1:0]   dir_z_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                           done_o,
  output logic signed [PT_W-1:0]         point_x_o,
  output logic signed [PT_W-1:0]         point_y_o,
  output logic signed [PT_W-1:0]         point_z_o,
  output logic [IDX_W-1:0]               corner_index_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg_q;
  entry_t           push;
  entry_t           head;
  logic [1:0]       inflight;
  logic [CW-1:0]    count;
  logic [CW:0]      occupancy;
  logic             take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size <= {SIZE_RST, SIZE_RST, SIZE_RST};
      cfg_q.rot  <= {ROT_Z_RST, ROT_Y_RST, ROT_X_RST};
      cfg_q.org  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOX_WIDTH:    cfg_q.size[0] <= cfg_data_i[SIZE_W-1:0];
        CFG_BOX_HEIGHT:   cfg_q.size[1] <= cfg_data_i[SIZE_W-1:0];
        CFG_BOX_DEPTH:    cfg_q.size[2] <= cfg_data_i[SIZE_W-1:0];
        CFG_ROT_ROW_X:    cfg_q.rot[0]  <= cfg_data_i[3*ROT_W-1:0];
        CFG_ROT_ROW_Y:    cfg_q.rot[1]  <= cfg_data_i[3*ROT_W-1:0];
        CFG_ROT_ROW_Z:    cfg_q.rot[2]  <= cfg_data_i[3*ROT_W-1:0];
        CFG_WORLD_ORIGIN: cfg_q.org     <= cfg_data_i[3*ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // words stored plus words still in the front stages
  assign occupancy = {1'b0, count} + (CW + 1)'(inflight);
  assign busy      = (occupancy >= (CW + 1)'(QUEUE_DEPTH));
  assign take      = start && !busy;

  bsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .inflight_o (inflight)
  );

  bsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .head_o  (head),
    .count_o (count)
  );

  bsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .cfg_i          (cfg_q),
    .done_o         (done_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .corner_index_o (corner_index_o)
  );

endmodule

`default_nettype wire

// ----- sv/bsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "box_support_point_defines.svh"

module bsp_checker import bsp_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic signed [DIR_W-1:0] dir_x_i,
  input wire logic signed [DIR_W-1:0] dir_y_i,
  input wire logic signed [DIR_W-1:0] dir_z_i,
  input wire logic                    done_o,
  input wire logic [IDX_W-1:0]        corner_index_o
);

  // every accepted word gives a result a fixed latency later, and only then
  `BSP_ASSERT_IMP(a_accept_to_done, clk_i, rst_ni, start && !busy, ##8 done_o)
  `BSP_ASSERT_IMP(a_done_has_source, clk_i, rst_ni, done_o, $past(start && !busy, 8))
  // a never-stalled result side keeps the queue far from full
  `BSP_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)
  // zero direction ties every corner, the first one wins
  `BSP_ASSERT_IMP(a_zero_dir_corner0, clk_i, rst_ni,
    done_o && $past(start && !busy && dir_x_i == '0 && dir_y_i == '0 && dir_z_i == '0, 8),
    corner_index_o == '0)

endmodule

bind box_support_point bsp_checker u_bsp_checker (.*);

`default_nettype wire

// ----- sim/tb_box_support_point.sv -----
`timescale 1ns / 1ps

module tb_box_support_point;
  import bsp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_LOGGED = 30;
  localparam int unsigned WORDS_PER_PHASE = 205;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // which corners sit on the positive half of each local axis
  localparam logic [2:0][7:0] CORNER_HALF = {8'hF0, 8'hCC, 8'h66};

  typedef enum {
    BOX_EXTREME, BOX_FLAT, BOX_HALF_STEP, BOX_AXIS, BOX_RANDOM
  } box_mode_e;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } query_t;

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic signed [PT_W-1:0] pz;
    logic [IDX_W-1:0]       idx;
  } support_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [DIR_W-1:0] dir_x_i, dir_y_i, dir_z_i;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic done_o;
  logic signed [PT_W-1:0] point_x_o, point_y_o, point_z_o;
  logic [IDX_W-1:0] corner_index_o;

  // shadow copy of the box registers
  logic [SIZE_W-1:0]  box_size [3];
  logic [3*ROT_W-1:0] rot_row [3];
  logic [3*ORG_W-1:0] world_origin;

  query_t   query_q [$];
  support_t support_q [$];
  query_t   next_query;
  support_t oldest_support;
  logic     word_taken;
  int unsigned send_gap_pct;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;

  box_support_point uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .corner_index_o (corner_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_LOGGED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0d want %0d", what, got, want));
    end
  endtask

  // support corner of the current box along one direction
  function automatic support_t predict_support(input query_t q);
    longint dir_v [3];
    longint rot_v [3][3];
    longint vert [8][3];
    longint proj, best, org_v, total, rnd;
    logic signed [ROT_W-1:0] rot_e;
    logic signed [ORG_W-1:0] org_e;
    int pick;
    support_t res;
    dir_v[0] = q.x;
    dir_v[1] = q.y;
    dir_v[2] = q.z;
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        rot_e = rot_row[a][j*ROT_W +: ROT_W];
        rot_v[a][j] = rot_e;
      end
    end
    // the full size in Q.8 is the half size in Q.9, so corners land in Q.23
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 3; j++) begin
        vert[i][j] = 0;
        for (int a = 0; a < 3; a++) begin
          if (CORNER_HALF[a][i]) vert[i][j] += longint'(box_size[a]) * rot_v[a][j];
          else vert[i][j] -= longint'(box_size[a]) * rot_v[a][j];
        end
      end
    end
    pick = 0;
    best = 0;
    for (int i = 0; i < 8; i++) begin
      proj = dir_v[0] * vert[i][0] + dir_v[1] * vert[i][1] + dir_v[2] * vert[i][2];
      if (i == 0 || proj > best) begin
        best = proj;
        pick = i;
      end
    end
    for (int j = 0; j < 3; j++) begin
      org_e = world_origin[j*ORG_W +: ORG_W];
      org_v = org_e;
      total = vert[pick][j] + (org_v <<< FRAC_SHIFT);
      // round half up, then clamp to the output range
      rnd = (total + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (rnd > 1048575) rnd = 1048575;
      if (rnd < -1048576) rnd = -1048576;
      case (j)
        0: res.px = PT_W'(rnd);
        1: res.py = PT_W'(rnd);
        default: res.pz = PT_W'(rnd);
      endcase
    end
    res.idx = IDX_W'(pick);
    return res;
  endfunction

  function automatic query_t random_query();
    query_t q;
    logic signed [DIR_W-1:0] pool [5];
    int kind;
    pool = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
    kind = $urandom_range(9);
    q.x = DIR_W'($urandom);
    q.y = DIR_W'($urandom);
    q.z = DIR_W'($urandom);
    case (kind)
      6: begin
        q.x = DIR_W'($urandom_range(8)) - 16'sd4;
        q.y = DIR_W'($urandom_range(8)) - 16'sd4;
        q.z = DIR_W'($urandom_range(8)) - 16'sd4;
      end
      7: begin
        if ($urandom_range(1)) q.x = '0;
        if ($urandom_range(1)) q.y = '0;
        else q.z = '0;
      end
      8: begin
        q.x = pool[$urandom_range(4)];
        q.y = pool[$urandom_range(4)];
        q.z = pool[$urandom_range(4)];
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_BOX_WIDTH:    box_size[0] = data[SIZE_W-1:0];
      CFG_BOX_HEIGHT:   box_size[1] = data[SIZE_W-1:0];
      CFG_BOX_DEPTH:    box_size[2] = data[SIZE_W-1:0];
      CFG_ROT_ROW_X:    rot_row[0] = data[3*ROT_W-1:0];
      CFG_ROT_ROW_Y:    rot_row[1] = data[3*ROT_W-1:0];
      CFG_ROT_ROW_Z:    rot_row[2] = data[3*ROT_W-1:0];
      CFG_WORLD_ORIGIN: world_origin = data[3*ORG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_box(input box_mode_e mode);
    logic [63:0] r64 [7];
    logic [CFG_DATA_W-1:0] val [7];
    logic signed [ROT_W-1:0] mag;
    int unsigned shift, flip, col;
    for (int k = 0; k < 7; k++) begin
      r64[k] = {$urandom, $urandom};
      val[k] = r64[k][CFG_DATA_W-1:0];
    end
    case (mode)
      BOX_EXTREME: begin
        // largest box, extreme rotation entries, origin at the range ends on x and y
        val[0] = {40'd0, 20'hFFFFF};
        val[1] = {40'd0, 20'hFFFFF};
        val[2] = {40'd0, 20'hFFFFF};
        val[3] = {12'd0, 16'h7FFF, 16'h8000, 16'h7FFF};
        val[4] = {12'd0, 16'h7FFF, 16'h8000, 16'h8000};
        val[5] = {12'd0, 16'h8000, 16'h7FFF, 16'h7FFF};
        val[6] = {20'hFFFFF, 20'h80000, 20'h7FFFF};
      end
      BOX_FLAT: begin
        // zero sizes with junk above the register width
        for (int k = 0; k < 3; k++) val[k] = {r64[k][39:0], 20'd0};
        write_reg(CFG_UNUSED, r64[6][CFG_DATA_W-1:0]);
      end
      BOX_HALF_STEP: begin
        // odd tiny sizes on the axes put corners exactly on half steps
        for (int k = 0; k < 3; k++) begin
          val[k] = CFG_DATA_W'($urandom_range(7) * 2 + 1);
          mag = $urandom_range(1) ? 16'sh4000 : -16'sh4000;
          val[k+3] = '0;
          val[k+3][k*ROT_W +: ROT_W] = mag;
        end
        val[6] = {20'($urandom_range(64)) - 20'd32, 20'($urandom_range(64)) - 20'd32,
                  20'($urandom_range(64)) - 20'd32};
      end
      BOX_AXIS: begin
        // signed and scaled axis permutation, many tied projections
        shift = $urandom_range(2);
        flip = $urandom_range(1);
        for (int k = 0; k < 3; k++) begin
          val[k] = CFG_DATA_W'($urandom_range(4096));
          mag = $urandom_range(1) ? 16'sh4000 : 16'sh2000;
          if ($urandom_range(1)) mag = -mag;
          col = flip ? (shift + 3 - k) % 3 : (shift + k) % 3;
          val[k+3] = '0;
          val[k+3][col*ROT_W +: ROT_W] = mag;
        end
      end
      default: ;
    endcase
    write_reg(CFG_BOX_WIDTH, val[0]);
    write_reg(CFG_BOX_HEIGHT, val[1]);
    write_reg(CFG_BOX_DEPTH, val[2]);
    write_reg(CFG_ROT_ROW_X, val[3]);
    write_reg(CFG_ROT_ROW_Y, val[4]);
    write_reg(CFG_ROT_ROW_Z, val[5]);
    write_reg(CFG_WORLD_ORIGIN, val[6]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (query_q.size() != 0 || start || support_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // sender: hold a word until it is taken, else maybe pause
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !word_taken)) begin
      if (query_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_query = query_q.pop_front();
        start <= 1'b1;
        dir_x_i <= next_query.x;
        dir_y_i <= next_query.y;
        dir_z_i <= next_query.z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result check, prediction of accepted words, stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = start && !busy;
      if (done_o === 1'b1) begin
        if (support_q.size() == 0) begin
          flag_mismatch("result with no query pending");
        end else begin
          oldest_support = support_q.pop_front();
          check_field("point_x", point_x_o, oldest_support.px);
          check_field("point_y", point_y_o, oldest_support.py);
          check_field("point_z", point_z_o, oldest_support.pz);
          check_field("corner_index", corner_index_o, oldest_support.idx);
        end
      end
      if (word_taken) support_q.push_back(predict_support({dir_x_i, dir_y_i, dir_z_i}));
      if (word_taken || done_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    query_t q;
    box_mode_e phase_mode [9];
    phase_mode = '{BOX_RANDOM, BOX_EXTREME, BOX_FLAT, BOX_HALF_STEP, BOX_AXIS,
                   BOX_RANDOM, BOX_AXIS, BOX_RANDOM, BOX_RANDOM};
    rst_ni = 1'b0;
    start = 1'b0;
    dir_x_i = '0;
    dir_y_i = '0;
    dir_z_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    word_taken = 1'b0;
    quiet_cycles = 0;
    mismatch_count = 0;
    send_gap_pct = 36;
    box_size = '{SIZE_RST, SIZE_RST, SIZE_RST};
    rot_row = '{ROT_X_RST, ROT_Y_RST, ROT_Z_RST};
    world_origin = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unit cube at reset: zero and axis directions tie, extremes pick each corner
    query_q.push_back('{16'sd0, 16'sd0, 16'sd0});
    query_q.push_back('{16'sd1, 16'sd0, 16'sd0});
    query_q.push_back('{16'sd0, -16'sd1, 16'sd0});
    query_q.push_back('{16'sd0, 16'sd0, 16'sd1});
    query_q.push_back('{-16'sd1, -16'sd1, -16'sd1});
    query_q.push_back('{16'sh7FFF, 16'sh8000, 16'sd0});
    for (int c = 0; c < 8; c++) begin
      q.x = c[0] ? 16'sh7FFF : 16'sh8000;
      q.y = c[1] ? 16'sh7FFF : 16'sh8000;
      q.z = c[2] ? 16'sh7FFF : 16'sh8000;
      query_q.push_back(q);
    end

    for (int p = 0; p < 9; p++) begin
      if (p != 0) load_box(phase_mode[p]);
      send_gap_pct = (p < 3) ? 36 : (p < 6) ? 45 : 0;
      repeat (WORDS_PER_PHASE) query_q.push_back(random_query());
      wait_drained();
    end

    if (mismatch_count == 0 && support_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- box_support_point.f -----
+incdir+sv
sv/bsp_pkg.sv
sv/bsp_front.sv
sv/bsp_queue.sv
sv/bsp_back.sv
sv/box_support_point.sv
sv/bsp_checker.sv
sim/tb_box_support_point.sv
